[design/bcld_pkg.sv]
// Shared types and constants for the button click / long / double detector.
package bcld_pkg;

    // Event codes carried in the result word
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } event_t;

    // Auto-repeat modes (code 3 acts as fixed repeat)
    localparam logic [1:0] REP_NONE = 2'd0;
    localparam logic [1:0] REP_PROG = 2'd2;

    // Progressive repeat schedule
    localparam logic [4:0]  REP_MID_AFTER  = 5'd5;
    localparam logic [4:0]  REP_FAST_AFTER = 5'd15;
    localparam logic [4:0]  REP_COUNT_MAX  = 5'd31;
    localparam logic [15:0] REP_MID_MS     = 16'd200;
    localparam logic [15:0] REP_FAST_MS    = 16'd50;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_INPUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SMART_LONG_MS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_MS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTOR_MODE = 3'd7;

    // Register reset values
    localparam logic [7:0]  RST_DEBOUNCE_MS   = 8'd40;
    localparam logic        RST_INVERT_INPUT  = 1'b1;
    localparam logic [15:0] RST_LONG_MS       = 16'd600;
    localparam logic        RST_CLICK_MODE    = 1'b0;
    localparam logic [1:0]  RST_REPEAT_MODE   = 2'd1;
    localparam logic [15:0] RST_SMART_LONG_MS = 16'd600;
    localparam logic [15:0] RST_DOUBLE_MS     = 16'd250;
    localparam logic        RST_DETECTOR_MODE = 1'b1;

    // Register file contents, handed to the datapath as one group
    typedef struct packed {
        logic [7:0]  debounce_ms;
        logic        invert_input;
        logic [15:0] long_ms;
        logic        click_mode;
        logic [1:0]  repeat_mode;
        logic [15:0] smart_long_ms;
        logic [15:0] double_ms;
        logic        detector_mode;
    } cfg_t;

endpackage

[design/bcld_cfg.sv]
// Configuration register file for the button detector.
module bcld_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bcld_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [bcld_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output bcld_pkg::cfg_t                      cfg
);

    bcld_pkg::cfg_t cfg_reg;

    // Register writes, one index per write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= bcld_pkg::RST_DEBOUNCE_MS;
            cfg_reg.invert_input  <= bcld_pkg::RST_INVERT_INPUT;
            cfg_reg.long_ms       <= bcld_pkg::RST_LONG_MS;
            cfg_reg.click_mode    <= bcld_pkg::RST_CLICK_MODE;
            cfg_reg.repeat_mode   <= bcld_pkg::RST_REPEAT_MODE;
            cfg_reg.smart_long_ms <= bcld_pkg::RST_SMART_LONG_MS;
            cfg_reg.double_ms     <= bcld_pkg::RST_DOUBLE_MS;
            cfg_reg.detector_mode <= bcld_pkg::RST_DETECTOR_MODE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bcld_pkg::CFG_DEBOUNCE_MS:   cfg_reg.debounce_ms   <= cfg_wdata[7:0];
                bcld_pkg::CFG_INVERT_INPUT:  cfg_reg.invert_input  <= cfg_wdata[0];
                bcld_pkg::CFG_LONG_MS:       cfg_reg.long_ms       <= cfg_wdata;
                bcld_pkg::CFG_CLICK_MODE:    cfg_reg.click_mode    <= cfg_wdata[0];
                bcld_pkg::CFG_REPEAT_MODE:   cfg_reg.repeat_mode   <= cfg_wdata[1:0];
                bcld_pkg::CFG_SMART_LONG_MS: cfg_reg.smart_long_ms <= cfg_wdata;
                bcld_pkg::CFG_DOUBLE_MS:     cfg_reg.double_ms     <= cfg_wdata;
                bcld_pkg::CFG_DETECTOR_MODE: cfg_reg.detector_mode <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/bcld_debounce.sv]
// Debouncer: level follows the sample once it has held longer than debounce_ms.
module bcld_debounce (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            raw_level,
    input  logic [31:0]     now_ms,
    input  bcld_pkg::cfg_t  cfg,
    output logic            level_next
);

    logic        last_sample_reg;
    logic        debounced_reg;
    logic [31:0] change_stamp_reg;

    logic        cur;
    logic [31:0] change_stamp_next;
    logic [31:0] stable_time;

    // A changed sample restarts the stable timer at the current time
    always_comb
    begin
        cur               = raw_level ^ cfg.invert_input;
        change_stamp_next = (cur != last_sample_reg) ? now_ms : change_stamp_reg;
        stable_time       = now_ms - change_stamp_next;
        level_next        = (stable_time > {24'd0, cfg.debounce_ms}) ? cur : debounced_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg  <= 1'b0;
            debounced_reg    <= 1'b0;
            change_stamp_reg <= 32'd0;
        end
        else if (en)
        begin
            last_sample_reg  <= cur;
            debounced_reg    <= level_next;
            change_stamp_reg <= change_stamp_next;
        end
    end

endmodule

[design/bcld_detect.sv]
// Event detector: simple click/long mode and smart double-click/repeat mode.
module bcld_detect (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             cur,
    input  logic [31:0]      now_ms,
    input  bcld_pkg::cfg_t   cfg,
    output bcld_pkg::event_t ev
);

    logic        prev_reg;
    logic [31:0] press_stamp_reg,   press_stamp_next;
    logic        hold_handled_reg,  hold_handled_next;
    logic        awaiting_reg,      awaiting_next;
    logic [31:0] release_stamp_reg, release_stamp_next;
    logic [31:0] repeat_stamp_reg,  repeat_stamp_next;
    logic [4:0]  repeat_count_reg,  repeat_count_next;

    logic        rise;
    logic        held;
    logic        fall;
    logic        open_window;
    logic [31:0] press_time;
    logic [31:0] repeat_time;
    logic [31:0] release_time;
    logic [15:0] interval;

    // Elapsed times, all modulo 2^32
    assign press_time   = now_ms - press_stamp_reg;
    assign repeat_time  = now_ms - repeat_stamp_reg;
    assign release_time = now_ms - release_stamp_reg;

    assign rise = cur & ~prev_reg;
    assign held = cur & prev_reg;
    assign fall = ~cur & prev_reg;

    // Repeat interval, shortened by the progressive schedule
    always_comb
    begin
        interval = cfg.smart_long_ms;
        if (cfg.repeat_mode == bcld_pkg::REP_PROG)
        begin
            if (repeat_count_reg > bcld_pkg::REP_FAST_AFTER)
                interval = bcld_pkg::REP_FAST_MS;
            else if (repeat_count_reg > bcld_pkg::REP_MID_AFTER)
                interval = bcld_pkg::REP_MID_MS;
        end
    end

    // Next state and event
    always_comb
    begin
        ev                 = bcld_pkg::EV_NONE;
        press_stamp_next   = press_stamp_reg;
        hold_handled_next  = hold_handled_reg;
        awaiting_next      = awaiting_reg;
        release_stamp_next = release_stamp_reg;
        repeat_stamp_next  = repeat_stamp_reg;
        repeat_count_next  = repeat_count_reg;
        open_window        = 1'b0;

        if (!cfg.detector_mode)
        begin
            // simple detector
            if (rise)
            begin
                press_stamp_next  = now_ms;
                hold_handled_next = 1'b0;
            end
            else if (held)
            begin
                if (!hold_handled_reg && (press_time > {16'd0, cfg.long_ms}))
                begin
                    hold_handled_next = 1'b1;
                    ev                = bcld_pkg::EV_LONG;
                end
            end
            else if (fall && !hold_handled_reg)
            begin
                ev = bcld_pkg::EV_CLICK;
            end
        end
        else
        begin
            // smart detector
            if (rise)
            begin
                press_stamp_next = now_ms;
                if (cfg.click_mode && awaiting_reg)
                begin
                    awaiting_next     = 1'b0;
                    hold_handled_next = 1'b1;
                    ev                = bcld_pkg::EV_DOUBLE;
                end
                else
                begin
                    hold_handled_next = 1'b0;
                    repeat_count_next = 5'd0;
                end
            end
            else if (held)
            begin
                if (press_time > {16'd0, cfg.smart_long_ms})
                begin
                    if (!hold_handled_reg)
                    begin
                        hold_handled_next = 1'b1;
                        awaiting_next     = 1'b0;
                        repeat_stamp_next = now_ms;
                        ev = (cfg.repeat_mode != bcld_pkg::REP_NONE) ?
                             bcld_pkg::EV_CLICK : bcld_pkg::EV_LONG;
                    end
                    else if ((cfg.repeat_mode != bcld_pkg::REP_NONE) &&
                             (repeat_time > {16'd0, interval}))
                    begin
                        repeat_stamp_next = now_ms;
                        if (repeat_count_reg < bcld_pkg::REP_COUNT_MAX)
                            repeat_count_next = repeat_count_reg + 5'd1;
                        ev = bcld_pkg::EV_CLICK;
                    end
                end
            end
            else if (fall && !hold_handled_reg)
            begin
                if (cfg.click_mode)
                begin
                    awaiting_next      = 1'b1;
                    release_stamp_next = now_ms;
                    open_window        = 1'b1;
                end
                else
                begin
                    ev = bcld_pkg::EV_CLICK;
                end
            end

            // Deferred click once the double-click window runs out; a window
            // opened by this very release has zero elapsed time
            if (!cur && cfg.click_mode && awaiting_reg && !open_window &&
                (release_time > {16'd0, cfg.double_ms}))
            begin
                awaiting_next = 1'b0;
                ev            = bcld_pkg::EV_CLICK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg          <= 1'b0;
            press_stamp_reg   <= 32'd0;
            hold_handled_reg  <= 1'b0;
            awaiting_reg      <= 1'b0;
            release_stamp_reg <= 32'd0;
            repeat_stamp_reg  <= 32'd0;
            repeat_count_reg  <= 5'd0;
        end
        else if (en)
        begin
            prev_reg          <= cur;
            press_stamp_reg   <= press_stamp_next;
            hold_handled_reg  <= hold_handled_next;
            awaiting_reg      <= awaiting_next;
            release_stamp_reg <= release_stamp_next;
            repeat_stamp_reg  <= repeat_stamp_next;
            repeat_count_reg  <= repeat_count_next;
        end
    end

endmodule

[design/button_click_long_double_detector.sv]
// Top level of the debounced button click / long press / double click detector.
//
// Takes one sample word (raw pin level plus a 32-bit millisecond timestamp)
// per clock and returns one result word per sample: the debounced level and an
// event code (none, click or repeat, long press, double click). Throughput is
// one word per cycle while the receiver takes results; a sample passes through
// the input register and then the result register, with the debounce and
// detector update done in the single logic stage between them. Configuration
// registers are written through cfg_we / cfg_addr / cfg_wdata and should only
// change while no sample is in flight.
module button_click_long_double_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample word: [0] raw_level, [32:1] now_ms, [39:33] zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [39:0]                         s_tdata,
    // result word: [0] stable_level, [2:1] event_res, [7:3] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,
    input  logic                                cfg_we,
    input  logic [bcld_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [bcld_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    bcld_pkg::cfg_t   cfg;
    bcld_pkg::event_t ev;

    logic        in_valid_reg;
    logic        raw_reg;
    logic [31:0] now_reg;
    logic        out_valid_reg;
    logic        stable_reg;
    logic [1:0]  event_reg;
    logic        advance;
    logic        level_next;

    // Pipeline control: stage moves when the result slot is free or draining
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    bcld_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcld_debounce u_debounce (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .raw_level  (raw_reg),
        .now_ms     (now_reg),
        .cfg        (cfg),
        .level_next (level_next)
    );

    bcld_detect u_detect (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .cur    (level_next),
        .now_ms (now_reg),
        .cfg    (cfg),
        .ev     (ev)
    );

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            raw_reg <= s_tdata[0];
            now_reg <= s_tdata[32:1];
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stable_reg <= level_next;
            event_reg  <= ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, event_reg, stable_reg};

endmodule

[design/bcld_checker.sv]
// Port-level checks for the button detector, bound to the top level.
module bcld_sva (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Long press and double click only happen while pressed
    a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:1] == bcld_pkg::EV_LONG ||
                     m_tdata[2:1] == bcld_pkg::EV_DOUBLE) |-> m_tdata[0])
        else $error("long or double event with button released");

    // A draining output never blocks the input side
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // An accepted sample passes the input register and reaches the output when not stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("accepted sample produced no result");

endmodule

bind button_click_long_double_detector bcld_sva u_bcld_sva (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/bcld_checker.sv]
`timescale 1ns / 1ps
// Checker for the button detector: predicts each result word and compares it.
module bcld_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [39:0]                     s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,
    input  logic                            cfg_we,
    input  logic [bcld_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [bcld_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              pending,
    output int                              fail_count
);

    typedef struct packed {
        logic             level;
        bcld_pkg::event_t ev;
    } press_result_t;

    // Results predicted but not yet seen on the master side
    press_result_t due_results[$];
    int unsigned   words_checked;

    // Register copy
    logic [7:0]  c_deb;
    logic        c_inv;
    logic [15:0] c_long;
    logic        c_click;
    logic [1:0]  c_rep;
    logic [15:0] c_smart;
    logic [15:0] c_dbl;
    logic        c_det;

    // Button tracking state
    logic        smp_last;
    logic        lvl_db;
    logic [31:0] chg_at;
    logic        lvl_prev;
    logic [31:0] press_at;
    logic        hold_done;
    logic        wait_second;
    logic [31:0] release_at;
    logic [31:0] rpt_at;
    logic [4:0]  rpt_cnt;

    initial fail_count = 0;

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("%0t: word %0d %s: got %0d, expected %0d",
                 $time, words_checked, what, got_v, want_v);
        fail_count++;
    endtask

    // Advance the button model by one sample and give its result
    task automatic advance_button(input logic raw, input logic [31:0] t,
                                  output press_result_t res);
        logic             cur;
        logic [31:0]      ival;
        bcld_pkg::event_t ev;
        // debounce: follow the sample once stable for more than debounce time
        cur = raw ^ c_inv;
        if (cur != smp_last)
            chg_at = t;
        if ((t - chg_at) > {24'd0, c_deb})
            lvl_db = cur;
        smp_last = cur;
        ev = bcld_pkg::EV_NONE;
        if (!c_det)
        begin
            // simple detector: long once, click on release when not long
            if (lvl_db && !lvl_prev)
            begin
                press_at = t;
                hold_done = 1'b0;
            end
            else if (lvl_db)
            begin
                if (!hold_done && (t - press_at) > {16'd0, c_long})
                begin
                    hold_done = 1'b1;
                    ev = bcld_pkg::EV_LONG;
                end
            end
            else if (lvl_prev && !hold_done)
                ev = bcld_pkg::EV_CLICK;
        end
        else if (lvl_db && !lvl_prev && c_click && wait_second)
        begin
            // second press inside the window
            wait_second = 1'b0;
            press_at = t;
            hold_done = 1'b1;
            ev = bcld_pkg::EV_DOUBLE;
        end
        else
        begin
            if (lvl_db && !lvl_prev)
            begin
                press_at = t;
                hold_done = 1'b0;
                rpt_cnt = 5'd0;
            end
            else if (lvl_db)
            begin
                if ((t - press_at) > {16'd0, c_smart})
                begin
                    if (!hold_done)
                    begin
                        hold_done = 1'b1;
                        wait_second = 1'b0;
                        rpt_at = t;
                        ev = (c_rep != bcld_pkg::REP_NONE) ?
                             bcld_pkg::EV_CLICK : bcld_pkg::EV_LONG;
                    end
                    else if (c_rep != bcld_pkg::REP_NONE)
                    begin
                        // repeat interval, shortened in progressive mode
                        ival = {16'd0, c_smart};
                        if (c_rep == bcld_pkg::REP_PROG)
                        begin
                            if (rpt_cnt > bcld_pkg::REP_FAST_AFTER)
                                ival = {16'd0, bcld_pkg::REP_FAST_MS};
                            else if (rpt_cnt > bcld_pkg::REP_MID_AFTER)
                                ival = {16'd0, bcld_pkg::REP_MID_MS};
                        end
                        if ((t - rpt_at) > ival)
                        begin
                            rpt_at = t;
                            if (rpt_cnt < bcld_pkg::REP_COUNT_MAX)
                                rpt_cnt = rpt_cnt + 5'd1;
                            ev = bcld_pkg::EV_CLICK;
                        end
                    end
                end
            end
            else if (lvl_prev && !hold_done)
            begin
                // release: click now or open the double-click window
                if (c_click)
                begin
                    wait_second = 1'b1;
                    release_at = t;
                end
                else
                    ev = bcld_pkg::EV_CLICK;
            end
            // window expiry gives the deferred click
            if (!lvl_db && c_click && wait_second && (t - release_at) > {16'd0, c_dbl})
            begin
                wait_second = 1'b0;
                ev = bcld_pkg::EV_CLICK;
            end
        end
        lvl_prev = lvl_db;
        res.level = lvl_db;
        res.ev = ev;
    endtask

    // Watch the three ports
    always @(posedge clk or negedge rst_n)
    begin : watch
        press_result_t want;
        press_result_t got;
        if (!rst_n)
        begin
            c_deb = bcld_pkg::RST_DEBOUNCE_MS;
            c_inv = bcld_pkg::RST_INVERT_INPUT;
            c_long = bcld_pkg::RST_LONG_MS;
            c_click = bcld_pkg::RST_CLICK_MODE;
            c_rep = bcld_pkg::RST_REPEAT_MODE;
            c_smart = bcld_pkg::RST_SMART_LONG_MS;
            c_dbl = bcld_pkg::RST_DOUBLE_MS;
            c_det = bcld_pkg::RST_DETECTOR_MODE;
            smp_last = 1'b0;
            lvl_db = 1'b0;
            chg_at = '0;
            lvl_prev = 1'b0;
            press_at = '0;
            hold_done = 1'b0;
            wait_second = 1'b0;
            release_at = '0;
            rpt_at = '0;
            rpt_cnt = '0;
            words_checked = 0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            // result side
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                    report_mismatch("unexpected result word", m_tdata, 0);
                else
                begin
                    want = due_results.pop_front();
                    if (m_tdata[0] !== want.level)
                        report_mismatch("stable_level", m_tdata[0], want.level);
                    if (m_tdata[2:1] !== want.ev)
                        report_mismatch("event_res", m_tdata[2:1], want.ev);
                end
                words_checked++;
            end
            // register writes
            if (cfg_we)
            begin
                case (cfg_addr)
                    bcld_pkg::CFG_DEBOUNCE_MS:   c_deb = cfg_wdata[7:0];
                    bcld_pkg::CFG_INVERT_INPUT:  c_inv = cfg_wdata[0];
                    bcld_pkg::CFG_LONG_MS:       c_long = cfg_wdata[15:0];
                    bcld_pkg::CFG_CLICK_MODE:    c_click = cfg_wdata[0];
                    bcld_pkg::CFG_REPEAT_MODE:   c_rep = cfg_wdata[1:0];
                    bcld_pkg::CFG_SMART_LONG_MS: c_smart = cfg_wdata[15:0];
                    bcld_pkg::CFG_DOUBLE_MS:     c_dbl = cfg_wdata[15:0];
                    bcld_pkg::CFG_DETECTOR_MODE: c_det = cfg_wdata[0];
                    default: ;
                endcase
            end
            // sample side
            if (s_tvalid && s_tready)
            begin
                advance_button(s_tdata[0], s_tdata[32:1], got);
                due_results.push_back(got);
            end
            pending <= due_results.size();
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, register settings, button gestures and verdict.
module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASES = 12;
    localparam int unsigned WORDS_PER_PHASE = 75;
    localparam int unsigned NUM_REGS = 1 << bcld_pkg::CFG_IDX_W;

    // Mode codes used in the settings table
    localparam logic [1:0] REP_FIXED    = 2'd1;
    localparam logic [1:0] REP_SPARE    = 2'd3;
    localparam logic       CLICK_SINGLE = 1'b0;
    localparam logic       CLICK_DOUBLE = 1'b1;
    localparam logic       DET_SIMPLE   = 1'b0;
    localparam logic       DET_SMART    = 1'b1;

    typedef struct packed {
        logic [7:0]  debounce;
        logic        invert;
        logic [15:0] long_thr;
        logic        click_mode;
        logic [1:0]  repeat_mode;
        logic [15:0] smart_thr;
        logic [15:0] double_win;
        logic        detector;
    } setting_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [39:0]                     s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [7:0]                      m_tdata;
    logic                            cfg_we = 1'b0;
    logic [bcld_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [bcld_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int          pending;
    int          fail_count;
    int unsigned cycles = 0;
    int unsigned words_sent = 0;
    int unsigned tx_idle = 6;
    int unsigned rx_idle = 54;
    logic [31:0] now_ms;
    setting_t    cur_set;

    button_click_long_double_detector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    bcld_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("button_click_long_double_detector verification failed");
            $finish;
        end
    end

    // Receiver stalls
    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= rx_idle);

    // Present one sample word and wait for it to be taken
    task automatic step_to(input logic raw, input int unsigned dt);
        now_ms = now_ms + dt;
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, now_ms, raw};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // Keep the button at one level for about span ms, in a few samples
    task automatic hold_level(input logic pressed, input int unsigned span,
                              input int unsigned parts);
        int unsigned slice;
        int unsigned spent;
        int unsigned dt;
        slice = span / parts + 1;
        spent = 0;
        while (spent <= span)
        begin
            dt = $urandom_range(slice, (slice + 1) / 2);
            step_to(pressed ^ cur_set.invert, dt);
            spent += dt;
        end
    endtask

    // Contact chatter around a level change
    task automatic bounce(input logic pressed);
        int unsigned n;
        n = $urandom_range(3, 0);
        repeat (n)
        begin
            step_to(pressed ^ cur_set.invert, $urandom_range(2, 0));
            step_to(~pressed ^ cur_set.invert, $urandom_range(2, 0));
        end
    endtask

    // Stop sending and let every result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers, one per cycle
    task automatic load_settings(input setting_t s);
        logic [bcld_pkg::CFG_IDX_W-1:0]  idx;
        logic [bcld_pkg::CFG_DATA_W-1:0] val;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            idx = bcld_pkg::CFG_IDX_W'(i);
            case (idx)
                bcld_pkg::CFG_DEBOUNCE_MS:   val = {8'd0, s.debounce};
                bcld_pkg::CFG_INVERT_INPUT:  val = {15'd0, s.invert};
                bcld_pkg::CFG_LONG_MS:       val = s.long_thr;
                bcld_pkg::CFG_CLICK_MODE:    val = {15'd0, s.click_mode};
                bcld_pkg::CFG_REPEAT_MODE:   val = {14'd0, s.repeat_mode};
                bcld_pkg::CFG_SMART_LONG_MS: val = s.smart_thr;
                bcld_pkg::CFG_DOUBLE_MS:     val = s.double_win;
                bcld_pkg::CFG_DETECTOR_MODE: val = {15'd0, s.detector};
                default:                     val = '0;
            endcase
            cfg_we <= 1'b1;
            cfg_addr <= idx;
            cfg_wdata <= val;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Settings per phase: fixed corners first, random after
    function automatic setting_t pick_setting(input int unsigned phase);
        case (phase)
            0: return '{8'd5, 1'b1, 16'd100, CLICK_DOUBLE, REP_FIXED, 16'd80, 16'd60,
                        DET_SMART};
            1: return '{8'd0, 1'b0, 16'd0, CLICK_SINGLE, bcld_pkg::REP_PROG, 16'd0, 16'd0,
                        DET_SMART};
            2: return '{8'd255, 1'b1, 16'hFFFF, CLICK_DOUBLE, bcld_pkg::REP_NONE, 16'hFFFF,
                        16'hFFFF, DET_SMART};
            3: return '{8'd10, 1'b0, 16'd150, CLICK_SINGLE, REP_SPARE, 16'd120, 16'd100,
                        DET_SMART};
            4: return '{8'd8, 1'b1, 16'd200, CLICK_DOUBLE, bcld_pkg::REP_PROG, 16'd40, 16'd150,
                        DET_SMART};
            5: return '{8'd20, 1'b0, 16'd300, CLICK_SINGLE, REP_FIXED, 16'd300, 16'd200,
                        DET_SIMPLE};
            6: return '{8'd0, 1'b1, 16'hFFFF, CLICK_DOUBLE, bcld_pkg::REP_PROG, 16'd300, 16'd30,
                        DET_SIMPLE};
            7: return '{8'd3, 1'b0, 16'd0, CLICK_DOUBLE, bcld_pkg::REP_PROG, 16'd30, 16'd20,
                        DET_SMART};
            default: return '{8'($urandom_range(30)), 1'($urandom_range(1)),
                               16'($urandom_range(400)), 1'($urandom_range(1)),
                               2'($urandom_range(3)), 16'($urandom_range(400)),
                               16'($urandom_range(300)), 1'($urandom_range(1))};
        endcase
    endfunction

    // One random gesture scaled to the current thresholds
    task automatic play_gesture();
        int unsigned pick;
        int unsigned thr;
        int unsigned gap;
        int unsigned n;
        pick = $urandom_range(99);
        thr = cur_set.detector ? cur_set.smart_thr : cur_set.long_thr;
        gap = (thr > 200) ? thr : 200;
        if (pick < 30)
        begin
            // single click, sometimes held past the threshold
            bounce(1'b1);
            hold_level(1'b1, cur_set.debounce + $urandom_range(thr + thr / 4 + 1, 1),
                       $urandom_range(4, 1));
            bounce(1'b0);
            hold_level(1'b0, cur_set.debounce + cur_set.double_win + $urandom_range(40, 1),
                       $urandom_range(5, 1));
        end
        else if (pick < 55)
        begin
            // two quick presses
            hold_level(1'b1, cur_set.debounce + $urandom_range(thr / 2 + 1, 1), 2);
            hold_level(1'b0, cur_set.debounce + $urandom_range(cur_set.double_win / 2 + 1, 1),
                       2);
            hold_level(1'b1, cur_set.debounce + $urandom_range(thr / 2 + 1, 1), 2);
            hold_level(1'b0, cur_set.debounce + cur_set.double_win + $urandom_range(40, 1), 3);
        end
        else if (pick < 85)
        begin
            // long hold with repeats
            bounce(1'b1);
            hold_level(1'b1, cur_set.debounce + thr + 1, $urandom_range(3, 1));
            n = $urandom_range(45, 2);
            repeat (n) step_to(~cur_set.invert, $urandom_range(gap + 60, 1));
            hold_level(1'b0, cur_set.debounce + cur_set.double_win + $urandom_range(40, 1),
                       $urandom_range(4, 1));
        end
        else
        begin
            // noise: random levels, short steps, time jumps
            n = $urandom_range(6, 1);
            repeat (n)
            begin
                if ($urandom_range(9) == 0)
                    now_ms = $urandom;
                step_to(1'($urandom_range(1)), $urandom_range(cur_set.debounce + 2, 0));
            end
        end
    endtask

    // Directed opening on the reset settings (active-low button)
    task automatic directed();
        step_to(1'b1, 0);
        step_to(1'b1, 50);
        step_to(1'b0, 10);
        step_to(1'b1, 3);
        step_to(1'b0, 3);
        step_to(1'b0, 41);
        step_to(1'b0, 300);
        step_to(1'b0, 301);
        step_to(1'b0, 601);
        step_to(1'b0, 50);
        step_to(1'b0, 560);
        step_to(1'b1, 5);
        step_to(1'b1, 41);
        step_to(1'b0, 5);
        step_to(1'b0, 41);
        step_to(1'b1, 100);
        step_to(1'b1, 41);
        now_ms = 32'hFFFF_FFFF;
        step_to(1'b1, 0);
        now_ms = 32'h0000_0000;
        step_to(1'b1, 0);
        step_to(1'b1, 0);
    endtask

    initial
    begin : stimulus
        int unsigned phase_end;
        cur_set = '{bcld_pkg::RST_DEBOUNCE_MS, bcld_pkg::RST_INVERT_INPUT,
                    bcld_pkg::RST_LONG_MS, bcld_pkg::RST_CLICK_MODE,
                    bcld_pkg::RST_REPEAT_MODE, bcld_pkg::RST_SMART_LONG_MS,
                    bcld_pkg::RST_DOUBLE_MS, bcld_pkg::RST_DETECTOR_MODE};
        now_ms = 32'hFFFF_FE00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        for (int unsigned p = 0; p < PHASES; p++)
        begin
            // settings change only with nothing in flight
            drain();
            if (p == 4)
            begin
                tx_idle = 54;
                rx_idle = 6;
            end
            else if (p == 8)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            cur_set = pick_setting(p);
            load_settings(cur_set);
            if ($urandom_range(1))
                now_ms = $urandom;
            phase_end = words_sent + WORDS_PER_PHASE;
            while (words_sent < phase_end)
                play_gesture();
        end
        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("button_click_long_double_detector verification clean");
        else
            $display("button_click_long_double_detector verification failed");
        $finish;
    end

endmodule
